FILE: src/clle_pkg.sv
package clle_pkg;

    // status codes of a result transfer
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // write enables for the slot store
    typedef struct packed {
        logic link_we;
        logic value_we;
    } t_mem_ctl;

endpackage

FILE: src/clle_if.sv
// request channel: one list operation
interface clle_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [6:0]  position;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

// result channel: status and list length
interface clle_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  list_length;

    modport source (output valid, output status, output list_length, input ready);
    modport sink   (input valid, input status, input list_length, output ready);
endinterface

FILE: src/cursor_linked_list_engine_unit.sv
// Static linked list engine over SLOTS slots. Slot 0 is the null link and
// slot SLOTS-1 is never used, so up to SLOTS-2 entries can be held.
// After reset the link memory is filled with the free chain in a single
// pass, during which no request is taken. A request is then handled
// one at a time by a small sequencer around a single-port link memory with
// registered read: the position walk follows one link per cycle. A rejected
// request goes straight to the result. The result sits in an output
// register, so the next request is taken while it waits.
module cursor_linked_list_engine_unit #(
    parameter int SLOTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clle_req_if.sink    i_req,
    clle_res_if.source  o_res
);
    import clle_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int PW = ((SW > 7) ? SW : 7) + 1;

    typedef enum logic [11:0] {
        S_INIT    = 12'b000000000001,
        S_IDLE    = 12'b000000000010,
        S_ALLOC   = 12'b000000000100,
        S_ALLOC_W = 12'b000000001000,
        S_WALK    = 12'b000000010000,
        S_LINK    = 12'b000000100000,
        S_LINK2   = 12'b000001000000,
        S_HEAD    = 12'b000010000000,
        S_HEAD_W  = 12'b000100000000,
        S_UNLINK  = 12'b001000000000,
        S_FREE    = 12'b010000000000,
        S_DONE    = 12'b100000000000
    } t_state;

    t_state        r_state, n_state;
    logic [SW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_free, n_free;
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_count, n_count;
    logic [SW-1:0] r_slot, n_slot;
    logic [SW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_fnext, n_fnext;
    logic          r_have, n_have;
    logic          r_type, n_type;
    logic [6:0]    r_left, n_left;
    logic [31:0]   r_value, n_value;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    logic [6:0]    r_out_len, n_out_len;

    t_mem_ctl      mem_ctl;
    logic [SW-1:0] mem_addr;
    logic [SW-1:0] mem_link;
    logic [SW-1:0] rd_link;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          ins_ok;
    logic          del_ok;
    logic [SW-1:0] init_link;

    clle_store #(.SLOTS(SLOTS)) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_link  (mem_link),
        .i_value (r_value),
        .o_link  (rd_link)
    );

    // position range checks against the current length
    assign pos_ext = PW'(i_req.position);
    assign cnt_ext = PW'(r_count);
    assign ins_ok  = (i_req.position != 7'd0) && (pos_ext <= cnt_ext + PW'(1));
    assign del_ok  = (i_req.position != 7'd0) && (pos_ext <= cnt_ext);

    // free chain at reset: slots 1 to SLOTS-3 point to the next slot
    assign init_link = ((r_idx != '0) && ({1'b0, r_idx} <= (SW+1)'(SLOTS - 3)))
                       ? r_idx + 1'b1 : '0;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.list_length = r_out_len;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_free       = r_free;
        n_head       = r_head;
        n_count      = r_count;
        n_slot       = r_slot;
        n_cur        = r_cur;
        n_fnext      = r_fnext;
        n_have       = r_have;
        n_type       = r_type;
        n_left       = r_left;
        n_value      = r_value;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        mem_ctl      = '0;
        mem_addr     = r_cur;
        mem_link     = '0;

        // result transfer frees the output register
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                mem_ctl.link_we = 1'b1;
                mem_addr        = r_idx;
                mem_link        = init_link;
                n_idx           = r_idx + 1'b1;
                if (r_idx == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_type   = i_req.req_type;
                    n_value  = i_req.value;
                    n_left   = i_req.position - 7'd1;
                    n_have   = 1'b0;
                    n_status = ST_DONE;
                    if (i_req.req_type == REQ_INSERT) begin
                        if (!ins_ok) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else if (r_free == '0) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_slot  = r_free;
                            n_state = S_ALLOC;
                        end
                    end else begin
                        if (!del_ok) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else if (i_req.position == 7'd1) begin
                            n_slot  = r_head;
                            n_state = S_HEAD;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_ALLOC: begin
                // store the element and fetch the next free slot
                mem_ctl.value_we = 1'b1;
                mem_addr         = r_slot;
                n_state          = S_ALLOC_W;
            end
            S_ALLOC_W: begin
                n_fnext = rd_link;
                if (r_left == 7'd0) begin
                    mem_ctl.link_we = 1'b1;
                    mem_addr        = r_slot;
                    mem_link        = r_head;
                    n_head          = r_slot;
                    n_free          = rd_link;
                    n_count         = r_count + 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // one link per cycle, address straight from the read data
                mem_addr = r_have ? rd_link : r_head;
                n_cur    = mem_addr;
                n_have   = 1'b1;
                n_left   = r_left - 7'd1;
                if (r_left == 7'd1) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                // read data is the link of the predecessor
                if (r_type == REQ_INSERT) begin
                    mem_ctl.link_we = 1'b1;
                    mem_addr        = r_slot;
                    mem_link        = rd_link;
                    n_state         = S_LINK2;
                end else begin
                    mem_addr = rd_link;
                    n_slot   = rd_link;
                    n_state  = S_UNLINK;
                end
            end
            S_LINK2: begin
                mem_ctl.link_we = 1'b1;
                mem_addr        = r_cur;
                mem_link        = r_slot;
                n_free          = r_fnext;
                n_count         = r_count + 1'b1;
                n_state         = S_DONE;
            end
            S_HEAD: begin
                mem_addr = r_head;
                n_state  = S_HEAD_W;
            end
            S_HEAD_W: begin
                n_head  = rd_link;
                n_state = S_FREE;
            end
            S_UNLINK: begin
                mem_ctl.link_we = 1'b1;
                mem_addr        = r_cur;
                mem_link        = rd_link;
                n_state         = S_FREE;
            end
            S_FREE: begin
                // return the slot to the front of the free list
                mem_ctl.link_we = 1'b1;
                mem_addr        = r_slot;
                mem_link        = r_free;
                n_free          = r_slot;
                n_count         = r_count - 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_len    = 7'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_free      <= SW'(1);
            r_head      <= '0;
            r_count     <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_free      <= n_free;
            r_head      <= n_head;
            r_count     <= n_count;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_cur        <= n_cur;
        r_fnext      <= n_fnext;
        r_type       <= n_type;
        r_left       <= n_left;
        r_value      <= n_value;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
    end

endmodule

FILE: src/clle_store.sv
module clle_store #(
    parameter int SLOTS = 128
) (
    input  logic                      i_clk,
    input  clle_pkg::t_mem_ctl        i_ctl,
    input  logic [$clog2(SLOTS)-1:0]  i_addr,
    input  logic [$clog2(SLOTS)-1:0]  i_link,
    input  logic [31:0]               i_value,
    output logic [$clog2(SLOTS)-1:0]  o_link
);
    import clle_pkg::*;

    localparam int SW = $clog2(SLOTS);

    logic [SW-1:0] r_link_mem [SLOTS];
    logic [31:0]   r_value_mem [SLOTS];
    logic [SW-1:0] r_link;

    // single-port link memory, registered read every cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) begin
            r_link_mem[i_addr] <= i_link;
        end
        r_link <= r_link_mem[i_addr];
    end

    // element memory, shares the slot address
    always_ff @(posedge i_clk) begin
        if (i_ctl.value_we) begin
            r_value_mem[i_addr] <= i_value;
        end
    end

    assign o_link = r_link;

endmodule

FILE: src/clle_check.sv
module clle_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_res_status,
    input logic [6:0] i_res_length
);
    import clle_pkg::*;

    logic [6:0] r_last_len;

    // length reported by the previous result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_len <= 7'd0;
        end else if (i_res_valid && i_res_ready) begin
            r_last_len <= i_res_length;
        end
    end

    // no request taken right after reset: the free chain is being built
    a_init_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_req_ready)
        else $error("request ready during free chain build");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status)
                                        && $stable(i_res_length))
        else $error("result dropped or changed while stalled");

    // status code is one of the defined ones
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_status == ST_DONE) || (i_res_status == ST_RANGE)
                        || (i_res_status == ST_FULL))
        else $error("undefined status code");

    // a failed request keeps the length, a done one moves it by one
    a_length_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready |->
            ((i_res_status != ST_DONE) && (i_res_length == r_last_len))
            || ((i_res_status == ST_DONE)
                && ((i_res_length == 7'(r_last_len + 7'd1))
                    || (i_res_length == 7'(r_last_len - 7'd1)))))
        else $error("list length step does not match status");

endmodule

bind cursor_linked_list_engine_unit clle_check u_clle_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_length (o_res.list_length)
);
